// ----- src/ctk_pkg.sv -----
package ctk_pkg;

  localparam int KEY_ROWS = 8;

  localparam logic [15:0] TIMER_RESET = 16'h3fff;
  localparam logic [15:0] CNT_WRAP    = 16'hffff;
  localparam logic [4:0]  IRQ_EN_MASK = 5'h1f;
  localparam int          ICR_SET_BIT = 7;
  localparam logic signed [15:0] JOY_THRESH = 16'sd16000;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_READ   = 3'd1,
    ACT_WRITE  = 3'd2,
    ACT_KEY    = 3'd3,
    ACT_BUTTON = 3'd4,
    ACT_AXIS   = 3'd5
  } ctk_action_e;

  typedef enum logic [3:0] {
    REG_PRA   = 4'h0,
    REG_PRB   = 4'h1,
    REG_DDRA  = 4'h2,
    REG_TALO  = 4'h4,
    REG_TAHI  = 4'h5,
    REG_TBLO  = 4'h6,
    REG_TBHI  = 4'h7,
    REG_ICR   = 4'hd,
    REG_CRA   = 4'he,
    REG_CRB   = 4'hf
  } ctk_reg_e;

  localparam logic [7:0] CRA_READ_VAL = 8'h01;
  localparam logic [7:0] CRB_READ_VAL = 8'h08;
  localparam logic [7:0] DDRA_READ_VAL = 8'hff;

  // Joystick bits, low active
  localparam int JOY_LEFT  = 0;
  localparam int JOY_RIGHT = 1;
  localparam int JOY_UP    = 2;
  localparam int JOY_DOWN  = 3;
  localparam int JOY_FIRE  = 4;

  // Configuration register indexes
  localparam logic [2:0] CFG_SWAP_ADDR = 3'd0;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         reg_addr;
    logic [7:0]         write_data;
    logic [2:0]         key_row;
    logic [2:0]         key_col;
    logic               pressed;
    logic               joy_device;
    logic [2:0]         joy_axis;
    logic signed [15:0] joy_value;
  } ctk_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } ctk_out_t;

  typedef struct packed {
    logic       irq;
    logic [7:0] rdata;
  } ctk_tmr_stat_t;

endpackage

// ----- src/ctk_timers.sv -----
module ctk_timers import ctk_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  ctk_in_t       item_i,
  output ctk_tmr_stat_t stat_o
);

  logic [15:0] a_cnt_q, a_cnt_d, a_reload_q, a_reload_d, a_shadow_q, a_shadow_d;
  logic        a_run_q, a_run_d, a_os_q, a_os_d, a_cnt_mode_q, a_cnt_mode_d;
  logic [15:0] b_cnt_q, b_cnt_d, b_reload_q, b_reload_d, b_shadow_q, b_shadow_d;
  logic        b_run_q, b_run_d, b_os_q, b_os_d;
  logic [1:0]  b_mode_q, b_mode_d;
  logic [1:0]  flags_q, flags_d;
  logic [4:0]  enable_q, enable_d;
  logic [15:0] a_next, b_next;
  logic        a_under, b_step;
  ctk_action_e act;

  assign act = ctk_action_e'(item_i.action);

  always_comb begin
    a_cnt_d      = a_cnt_q;
    a_reload_d   = a_reload_q;
    a_shadow_d   = a_shadow_q;
    a_run_d      = a_run_q;
    a_os_d       = a_os_q;
    a_cnt_mode_d = a_cnt_mode_q;
    b_cnt_d      = b_cnt_q;
    b_reload_d   = b_reload_q;
    b_shadow_d   = b_shadow_q;
    b_run_d      = b_run_q;
    b_os_d       = b_os_q;
    b_mode_d     = b_mode_q;
    flags_d      = flags_q;
    enable_d     = enable_q;
    a_next       = a_cnt_q;
    b_next       = b_cnt_q;
    a_under      = 1'b0;
    b_step       = 1'b0;
    stat_o       = '0;
    if (go_i) begin
      case (act)
        ACT_TICK: begin
          if (a_run_q) begin
            a_next = a_cnt_mode_q ? a_cnt_q : a_cnt_q - 16'd1;
            if (a_next == CNT_WRAP) begin
              flags_d[0] = 1'b1;
              a_under    = 1'b1;
              if (a_os_q) begin
                a_run_d = 1'b0;
              end else begin
                a_next = a_reload_q;
              end
            end
            a_cnt_d    = a_next;
            a_shadow_d = a_next;
          end
          // Mode 0 counts the clock, modes 2 and 3 count timer A underflows
          b_step = b_run_q && ((b_mode_q == 2'd0) || (b_mode_q[1] && a_under));
          if (b_step) begin
            b_next = b_cnt_q - 16'd1;
            if (b_next == CNT_WRAP) begin
              flags_d[1] = 1'b1;
              if (b_os_q) begin
                b_run_d = 1'b0;
              end else begin
                b_next = b_reload_q;
              end
            end
            b_cnt_d    = b_next;
            b_shadow_d = b_next;
          end
          stat_o.irq = |(flags_d & enable_q[1:0]);
        end
        ACT_READ: begin
          case (item_i.reg_addr)
            REG_TALO: stat_o.rdata = a_shadow_q[7:0];
            REG_TAHI: stat_o.rdata = a_shadow_q[15:8];
            REG_TBLO: stat_o.rdata = b_shadow_q[7:0];
            REG_TBHI: stat_o.rdata = b_shadow_q[15:8];
            REG_ICR: begin
              stat_o.rdata = {6'd0, flags_q};
              flags_d      = '0;
            end
            REG_CRA:  stat_o.rdata = CRA_READ_VAL;
            REG_CRB:  stat_o.rdata = CRB_READ_VAL;
            default:  stat_o.rdata = '0;
          endcase
        end
        ACT_WRITE: begin
          case (item_i.reg_addr)
            REG_TALO: a_reload_d[7:0]  = item_i.write_data;
            REG_TAHI: a_reload_d[15:8] = item_i.write_data;
            REG_TBLO: b_reload_d[7:0]  = item_i.write_data;
            REG_TBHI: b_reload_d[15:8] = item_i.write_data;
            REG_ICR: begin
              if (item_i.write_data[ICR_SET_BIT]) begin
                enable_d = enable_q | (item_i.write_data[4:0] & IRQ_EN_MASK);
              end else begin
                enable_d = enable_q & ~(item_i.write_data[4:0] & IRQ_EN_MASK);
              end
            end
            REG_CRA: begin
              a_run_d      = item_i.write_data[0];
              a_os_d       = item_i.write_data[3];
              a_cnt_mode_d = item_i.write_data[5];
              if (item_i.write_data[4]) begin
                a_cnt_d = a_reload_q;
              end
            end
            REG_CRB: begin
              b_run_d  = item_i.write_data[0];
              b_os_d   = item_i.write_data[3];
              b_mode_d = item_i.write_data[6:5];
              if (item_i.write_data[4]) begin
                b_cnt_d = b_reload_q;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q      <= TIMER_RESET;
      a_reload_q   <= TIMER_RESET;
      a_shadow_q   <= '0;
      a_run_q      <= 1'b1;
      a_os_q       <= 1'b0;
      a_cnt_mode_q <= 1'b0;
      b_cnt_q      <= TIMER_RESET;
      b_reload_q   <= TIMER_RESET;
      b_shadow_q   <= '0;
      b_run_q      <= 1'b0;
      b_os_q       <= 1'b0;
      b_mode_q     <= 2'd0;
      flags_q      <= '0;
      enable_q     <= 5'h01;
    end else begin
      a_cnt_q      <= a_cnt_d;
      a_reload_q   <= a_reload_d;
      a_shadow_q   <= a_shadow_d;
      a_run_q      <= a_run_d;
      a_os_q       <= a_os_d;
      a_cnt_mode_q <= a_cnt_mode_d;
      b_cnt_q      <= b_cnt_d;
      b_reload_q   <= b_reload_d;
      b_shadow_q   <= b_shadow_d;
      b_run_q      <= b_run_d;
      b_os_q       <= b_os_d;
      b_mode_q     <= b_mode_d;
      flags_q      <= flags_d;
      enable_q     <= enable_d;
    end
  end

  a_free_run_keeps_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && act == ACT_TICK && a_run_q && !a_os_q |=> a_run_q)
    else $error("timer A stopped while free running");

  b_oneshot_stops_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && act == ACT_TICK && b_step && b_os_q && b_cnt_q == 16'd0 |=> !b_run_q && flags_q[1])
    else $error("timer B one-shot did not stop and flag on underflow");

  icr_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && act == ACT_READ && item_i.reg_addr == REG_ICR |=> flags_q == 2'b00)
    else $error("interrupt flags not cleared by ICR read");

endmodule

// ----- src/ctk_keyport.sv -----
module ctk_keyport import ctk_pkg::*; #(
  parameter int KeyRows = KEY_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  ctk_in_t    item_i,
  input  logic       swap_i,
  output logic [7:0] rdata_o
);

  localparam int ScanRows = (KeyRows < 8) ? KeyRows : 8;

  logic [7:0] key_q [KeyRows];
  logic [7:0] key_d [KeyRows];
  logic [7:0] joy_q [2];
  logic [7:0] joy_d [2];
  logic [7:0] row_sel_q, row_sel_d;
  logic [7:0] col_bit, port_b, axis_m;
  logic       dev, lo_act, hi_act;
  ctk_action_e act;

  assign act     = ctk_action_e'(item_i.action);
  assign dev     = item_i.joy_device ^ swap_i;
  assign col_bit = 8'd1 << item_i.key_col;
  assign lo_act  = $signed(item_i.joy_value) < -JOY_THRESH;
  assign hi_act  = $signed(item_i.joy_value) > JOY_THRESH;

  // Merge the selected rows, low active select
  always_comb begin
    port_b = 8'hff;
    for (int i = 0; i < ScanRows; i++) begin
      if (!row_sel_q[i]) begin
        port_b = port_b & key_q[i];
      end
    end
  end

  always_comb begin
    axis_m = joy_q[dev];
    if (item_i.joy_axis == 3'd0) begin
      axis_m[JOY_LEFT]  = !lo_act;
      axis_m[JOY_RIGHT] = !hi_act;
    end else begin
      axis_m[JOY_UP]    = !lo_act;
      axis_m[JOY_DOWN]  = !hi_act;
    end
  end

  always_comb begin
    key_d     = key_q;
    joy_d     = joy_q;
    row_sel_d = row_sel_q;
    rdata_o   = '0;
    if (go_i) begin
      case (act)
        ACT_READ: begin
          case (item_i.reg_addr)
            REG_PRA:  rdata_o = joy_q[0];
            REG_PRB:  rdata_o = port_b & joy_q[1];
            REG_DDRA: rdata_o = DDRA_READ_VAL;
            default:  rdata_o = '0;
          endcase
        end
        ACT_WRITE: begin
          if (item_i.reg_addr == REG_PRA) begin
            row_sel_d = item_i.write_data;
          end
        end
        ACT_KEY: begin
          for (int r = 0; r < KeyRows; r++) begin
            if (32'(item_i.key_row) == r) begin
              key_d[r] = item_i.pressed ? (key_q[r] & ~col_bit) : (key_q[r] | col_bit);
            end
          end
        end
        ACT_BUTTON: begin
          joy_d[dev][JOY_FIRE] = !item_i.pressed;
        end
        ACT_AXIS: begin
          if (item_i.joy_axis <= 3'd1) begin
            joy_d[dev] = axis_m;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KeyRows; r++) begin
        key_q[r] <= 8'hff;
      end
      joy_q[0]  <= 8'hff;
      joy_q[1]  <= 8'hff;
      row_sel_q <= 8'hff;
    end else begin
      key_q     <= key_d;
      joy_q     <= joy_d;
      row_sel_q <= row_sel_d;
    end
  end

endmodule

// ----- src/cia_timers_keyboard_port_unit.sv -----
// A beat accepted into the input register is processed and written to the
// result register, where its result can be taken; a stalled output holds it back.
// Throughput: one beat per cycle while the output is not stalled; timer, flag and
// key state update as a beat moves from the input register to the result register.
// Reset (rst_ni low, async): timers at 0x3fff, timer A running, timer B
// stopped, flags clear, mask 0x01, rows, keys and joysticks all ones.
module cia_timers_keyboard_port_unit import ctk_pkg::*; #(
  parameter int KeyRows = KEY_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ctk_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ctk_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          in_valid_q, in_valid_d;
  ctk_in_t       item_q;
  logic          out_valid_q, out_valid_d;
  ctk_out_t      out_q, out_d;
  logic          advance, go, swap_q;
  ctk_tmr_stat_t tmr_stat;
  logic [7:0]    kp_rdata;

  assign advance    = !out_valid_q || !out_stall_i;
  assign go         = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_valid_d = in_valid_i || (in_valid_q && !advance);
  assign out_valid_d = go || (out_valid_q && out_stall_i);

  always_comb begin
    out_d.irq       = tmr_stat.irq;
    out_d.read_data = (ctk_action_e'(item_q.action) == ACT_READ) ?
                      (tmr_stat.rdata | kp_rdata) : 8'd0;
  end

  ctk_timers u_timers (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .item_i (item_q),
    .stat_o (tmr_stat)
  );

  ctk_keyport #(
    .KeyRows (KeyRows)
  ) u_keyport (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .item_i  (item_q),
    .swap_i  (swap_q),
    .rdata_o (kp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      swap_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && paddr == CFG_SWAP_ADDR) begin
        swap_q <= pwdata[0];
      end
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q <= in_data_i;
    end
    if (go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == CFG_SWAP_ADDR) ? {31'd0, swap_q} : 32'd0;

  go_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_o)
    else $error("processed beat did not reach the result register");

  stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  output_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !go |=> !out_valid_o)
    else $error("result beat repeated after it was taken");

endmodule
